// ----- hw/rtl/rrr_pkg.sv -----
// Shared types and constants for the ray reflect/refract core.
// Used by rrr_lane, rrr_isqrt and ray_reflect_refract_core; depends on nothing.
package rrr_pkg;

    localparam int FRAC_BITS_DEF = 13;
    localparam int ETA_BITS      = 14;
    localparam int COMP_W        = 16;
    localparam int ETA_W         = 16;
    localparam int PROD_W        = 32;
    localparam int SUM_W         = 35;
    localparam int P_W           = 32;
    localparam int SQ_W          = 62;
    localparam int RAD_W         = 64;
    localparam int ROOT_W        = 32;
    localparam int RES_W         = 51;
    localparam int SQRT_STAGES   = 32;

    localparam longint PERP_LIMIT = 64'sd2147483647;

    localparam logic OP_REFLECT = 1'b0;
    localparam logic OP_REFRACT = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [COMP_W-1:0] dir_x;
        logic signed [COMP_W-1:0] dir_y;
        logic signed [COMP_W-1:0] dir_z;
        logic signed [COMP_W-1:0] norm_x;
        logic signed [COMP_W-1:0] norm_y;
        logic signed [COMP_W-1:0] norm_z;
        logic        [ETA_W-1:0]  eta_ratio;
    } t_rrr_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     saturated;
    } t_rrr_out;

    typedef struct packed {
        logic                     op;
        logic signed [COMP_W-1:0] dir;
        logic signed [COMP_W-1:0] norm;
        logic        [ETA_W-1:0]  eta;
    } t_rrr_lane_in;

endpackage

// ----- hw/rtl/ray_reflect_refract_core.sv -----
// Top level of the ray reflect/refract core: three component lanes, dot-product and
// norm merging, shared square root pipeline and output register.
// Depends on rrr_pkg, rrr_lane and rrr_isqrt.
//
// Accepts one item per clock and returns one result per item in order. The pipeline
// has 9 stages for products, dot product, perpendicular part and its squared norm,
// 32 stages for the bit-per-stage square root, and 3 for the final scaling,
// saturation and output register. All stages advance together; the input is
// stalled only while a result waits at the output.
module ray_reflect_refract_core import rrr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_rrr_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_rrr_out o_data
);

    localparam int DOT_W = SUM_W - FRAC_BITS + 1;
    localparam int LAT   = SQRT_STAGES + 12;

    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [RAD_W-1:0] HALF_R = RAD_W'(1) << (FRAC_BITS - 1);
    localparam logic [RAD_W-1:0] ONE_R  = RAD_W'(1) << FRAC_BITS;

    logic [LAT-1:0]             r_vld;
    logic signed [DOT_W-1:0]    r_dotq;
    logic [RAD_W-1:0]           r_sum;
    logic [RAD_W-1:0]           r_rad;
    t_rrr_out                   r_out;

    logic                       adv;
    t_rrr_lane_in               lane_in [3];
    logic signed [PROD_W-1:0]   prod    [3];
    logic [SQ_W-1:0]            sq      [3];
    logic signed [COMP_W-1:0]   res     [3];
    logic                       sat     [3];
    logic [ROOT_W-1:0]          root;
    logic signed [SUM_W-1:0]    dot_sum;
    logic signed [SUM_W-1:0]    dot_sh;
    logic [RAD_W-1:0]           ls;
    logic [RAD_W-1:0]           dev;

    assign adv     = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT-1];
    assign o_data  = r_out;

    assign lane_in[0] = '{op: i_data.op, dir: i_data.dir_x, norm: i_data.norm_x,
                          eta: i_data.eta_ratio};
    assign lane_in[1] = '{op: i_data.op, dir: i_data.dir_y, norm: i_data.norm_y,
                          eta: i_data.eta_ratio};
    assign lane_in[2] = '{op: i_data.op, dir: i_data.dir_z, norm: i_data.norm_z,
                          eta: i_data.eta_ratio};

    for (genvar l = 0; l < 3; l++) begin : g_lane
        rrr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_item (lane_in[l]),
            .o_prod (prod[l]),
            .i_dotq (r_dotq),
            .o_sq   (sq[l]),
            .i_root (root),
            .o_res  (res[l]),
            .o_sat  (sat[l])
        );
    end

    assign dot_sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + HALF_S;
    assign dot_sh  = dot_sum >>> FRAC_BITS;
    assign ls      = r_sum >> FRAC_BITS;
    assign dev     = (ls > ONE_R) ? ls - ONE_R : ONE_R - ls;

    rrr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_rad  (r_rad),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dotq          <= DOT_W'(dot_sh);
            r_sum           <= RAD_W'(sq[0]) + RAD_W'(sq[1]) + RAD_W'(sq[2]) + HALF_R;
            r_rad           <= dev << FRAC_BITS;
            r_out.out_x     <= res[0];
            r_out.out_y     <= res[1];
            r_out.out_z     <= res[2];
            r_out.saturated <= sat[0] || sat[1] || sat[2];
        end
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_vld[LAT-2]) |=> !o_valid)
        else $error("result repeated after transfer out");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// ----- hw/rtl/rrr_lane.sv -----
// One component lane: products, reflect term, perpendicular part, square and final combine.
// Depends on rrr_pkg; receives the merged dot product and square root from the top level.
module rrr_lane import rrr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_adv,
    input  t_rrr_lane_in                    i_item,
    output logic signed [PROD_W-1:0]        o_prod,
    input  logic signed [SUM_W-FRAC_BITS:0] i_dotq,
    output logic        [SQ_W-1:0]          o_sq,
    input  logic        [ROOT_W-1:0]        i_root,
    output logic signed [COMP_W-1:0]        o_res,
    output logic                            o_sat
);

    localparam int DOT_W = SUM_W - FRAC_BITS + 1;
    localparam int C_W   = (DOT_W + 1 > FRAC_BITS + 2) ? DOT_W + 1 : FRAC_BITS + 2;
    localparam int CN_W  = C_W + COMP_W;
    localparam int T_W   = CN_W + 1;
    localparam int E_W   = T_W + ETA_W + 1;
    localparam int M_W   = DOT_W + COMP_W + 1;
    localparam int RN_W  = ROOT_W + 1 + COMP_W;
    localparam int HOLD  = SQRT_STAGES + 3;

    localparam logic signed [C_W-1:0]  ONE_C   = C_W'(1) <<< FRAC_BITS;
    localparam logic signed [CN_W:0]   HALF_CN = (CN_W + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [M_W:0]    HALF_M  = (M_W + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [E_W:0]    HALF_E  = (E_W + 1)'(1) <<< (ETA_BITS - 1);
    localparam logic signed [RN_W:0]   HALF_RN = (RN_W + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [E_W:0]    LIM_E   = (E_W + 1)'(PERP_LIMIT);
    localparam logic signed [RES_W-1:0] MAX_O  = RES_W'(32767);
    localparam logic signed [RES_W-1:0] MIN_O  = -RES_W'(32768);

    typedef struct packed {
        logic                     op;
        logic signed [COMP_W-1:0] norm;
        logic signed [P_W-1:0]    p;
        logic                     psat;
        logic signed [RES_W-1:0]  refl;
    } t_hold;

    t_rrr_lane_in r_it1, r_it2, r_it3, r_it4, r_it5, r_it6;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [CN_W-1:0]        r_cn;
    logic signed [DOT_W+COMP_W-1:0] r_m;
    logic signed [T_W-1:0]         r_t;
    logic signed [RES_W-1:0]       r_refl4, r_refl5, r_refl6;
    logic signed [E_W-1:0]         r_e;
    logic signed [P_W-1:0]         r_p;
    logic                          r_psat;
    logic        [SQ_W-1:0]        r_sq;
    t_hold                         r_hold [HOLD];
    t_hold                         r_h42;
    logic signed [RN_W-1:0]        r_rn;
    logic signed [COMP_W-1:0]      r_res;
    logic                          r_sat;

    logic signed [DOT_W:0]      neg_dot;
    logic signed [C_W-1:0]      c_ext;
    logic signed [C_W-1:0]      c_val;
    logic signed [CN_W:0]       cn_rnd;
    logic signed [M_W-1:0]      m2;
    logic signed [M_W:0]        m_rnd;
    logic signed [E_W:0]        e_rnd;
    logic signed [E_W:0]        p_clamp;
    logic                       p_clip;
    logic        [P_W-2:0]      p_mag;
    logic signed [RN_W:0]       rn_rnd;
    logic signed [RES_W-1:0]    refr;
    logic signed [RES_W-1:0]    res_full;
    logic signed [COMP_W-1:0]   res_clip;
    logic                       res_sat;

    assign neg_dot = -{i_dotq[DOT_W-1], i_dotq};
    assign c_ext   = C_W'(neg_dot);
    assign c_val   = (c_ext > ONE_C) ? ONE_C : c_ext;

    assign cn_rnd = ($signed({r_cn[CN_W-1], r_cn}) + HALF_CN) >>> FRAC_BITS;
    assign m2     = $signed({r_m, 1'b0});
    assign m_rnd  = ($signed({m2[M_W-1], m2}) + HALF_M) >>> FRAC_BITS;

    assign e_rnd = ($signed({r_e[E_W-1], r_e}) + HALF_E) >>> ETA_BITS;

    always_comb begin
        p_clip  = 1'b0;
        p_clamp = e_rnd;
        if (e_rnd > LIM_E) begin
            p_clamp = LIM_E;
            p_clip  = 1'b1;
        end else if (e_rnd < -LIM_E) begin
            p_clamp = -LIM_E;
            p_clip  = 1'b1;
        end
    end

    assign p_mag = (P_W - 1)'(r_p[P_W-1] ? -r_p : r_p);

    assign rn_rnd   = ($signed({r_rn[RN_W-1], r_rn}) + HALF_RN) >>> FRAC_BITS;
    assign refr     = RES_W'(r_h42.p) - RES_W'(rn_rnd);
    assign res_full = (r_h42.op == OP_REFRACT) ? refr : r_h42.refl;

    always_comb begin
        res_sat  = 1'b0;
        res_clip = COMP_W'(res_full);
        if (res_full > MAX_O) begin
            res_clip = COMP_W'(MAX_O);
            res_sat  = 1'b1;
        end else if (res_full < MIN_O) begin
            res_clip = COMP_W'(MIN_O);
            res_sat  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod  <= i_item.dir * i_item.norm;
            r_it1   <= i_item;
            r_it2   <= r_it1;
            r_cn    <= c_val * r_it2.norm;
            r_m     <= i_dotq * r_it2.norm;
            r_it3   <= r_it2;
            r_t     <= T_W'(r_it3.dir) + cn_rnd;
            r_refl4 <= RES_W'(r_it3.dir) - RES_W'(m_rnd);
            r_it4   <= r_it3;
            r_e     <= $signed({1'b0, r_it4.eta}) * r_t;
            r_refl5 <= r_refl4;
            r_it5   <= r_it4;
            r_p     <= P_W'(p_clamp);
            r_psat  <= p_clip;
            r_refl6 <= r_refl5;
            r_it6   <= r_it5;
            r_sq    <= p_mag * p_mag;
            r_hold[0] <= '{op: r_it6.op, norm: r_it6.norm, p: r_p,
                           psat: r_psat && (r_it6.op == OP_REFRACT), refl: r_refl6};
            for (int k = 1; k < HOLD; k++) begin
                r_hold[k] <= r_hold[k-1];
            end
            r_rn  <= $signed({1'b0, i_root}) * r_hold[HOLD-1].norm;
            r_h42 <= r_hold[HOLD-1];
            r_res <= res_clip;
            r_sat <= res_sat || r_h42.psat;
        end
    end

    assign o_prod = r_prod;
    assign o_sq   = r_sq;
    assign o_res  = r_res;
    assign o_sat  = r_sat;

endmodule

// ----- hw/rtl/rrr_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, truncating.
// Depends on rrr_pkg.
module rrr_isqrt import rrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0] r_x   [SQRT_STAGES-1];
    logic [RAD_W-1:0] r_res [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0] x_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] trial;
        logic             take;

        if (k == 0) begin : g_first
            assign x_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign res_in = r_res[k-1];
        end

        assign trial = res_in + BIT;
        assign take  = (x_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_res[k] <= take ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end

        if (k < SQRT_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_x[k] <= take ? x_in - trial : x_in;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STAGES-1][ROOT_W-1:0];

endmodule
